// ===== rtl/rau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned KindW = 3;

  typedef enum logic [KindW-1:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_MUL  = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_NORM = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDEF = 2'd1,
    ST_OVF   = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               a_less;
    logic               a_equal;
    logic [1:0]         status;
  } out_item_t;

  // Classified transaction handed from front to back.
  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
    logic [63:0] den;
    logic        a_less;
    logic        a_equal;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_TWOS,
    BK_ODDX,
    BK_LOOP,
    BK_DIVN,
    BK_DIVD,
    BK_DONE
  } bk_state_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_MUL1,
    FR_MUL2,
    FR_SUM,
    FR_PUSH
  } fr_state_t;

endpackage : rau_pkg
`default_nettype wire

// ===== rtl/rau_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rau_front
// Accepts a transaction, forms raw numerator/denominator and compare flags.
// ----------------------------------------------------------------------------
module rau_front
  import rau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire in_item_t in_item,
  output logic          busy,
  output logic          push,
  output job_t          job,
  input  wire logic     q_full
);

  fr_state_t state, state_next;
  in_item_t  op;
  // shared 33x33 signed multiplier for the cross products, products registered
  logic signed [63:0] p1, p2;
  logic signed [32:0] m_x, m_y;
  logic signed [65:0] prod;
  logic signed [65:0] n_raw, d_raw;
  logic signed [65:0] n_fix, d_fix;

  always_comb begin
    m_x = '0;
    m_y = '0;
    case (state)
      FR_MUL1: begin
        m_x = 33'(op.a_num);
        m_y = (op.kind == KIND_MUL) ? 33'(op.b_num) : $signed({2'b0, op.b_den});
      end
      FR_MUL2: begin
        m_x = (op.kind == KIND_DIV) ? $signed({2'b0, op.a_den}) : 33'(op.b_num);
        m_y = (op.kind == KIND_DIV) ? 33'(op.b_num) : $signed({2'b0, op.a_den});
      end
      default: ;
    endcase
  end
  assign prod = 66'(m_x * m_y);

  always_comb begin
    logic [61:0] dd;
    dd = 62'(op.a_den) * 62'(op.b_den);
    case (op.kind)
      KIND_ADD: begin n_raw = 66'(p1) + 66'(p2); d_raw = $signed({4'b0, dd}); end
      KIND_SUB: begin n_raw = 66'(p1) - 66'(p2); d_raw = $signed({4'b0, dd}); end
      KIND_MUL: begin n_raw = 66'(p1);           d_raw = $signed({4'b0, dd}); end
      KIND_DIV: begin n_raw = 66'(p1);           d_raw = 66'(p2); end
      default:  begin n_raw = 66'(op.a_num);     d_raw = $signed({35'b0, op.a_den}); end
    endcase
    if (d_raw < 0) begin
      n_fix = -n_raw;
      d_fix = -d_raw;
    end else begin
      n_fix = n_raw;
      d_fix = d_raw;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: if (start) state_next = FR_MUL1;
      FR_MUL1: state_next = FR_MUL2;
      FR_MUL2: state_next = FR_SUM;
      FR_SUM:  state_next = FR_PUSH;
      FR_PUSH: if (!q_full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  assign busy = (state != FR_IDLE);
  assign push = (state == FR_PUSH) && !q_full;

  always_ff @(posedge clk) begin
    if (rst) state <= FR_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == FR_IDLE && start) op <= in_item;
    if (state == FR_MUL1) p1 <= prod[63:0];
    if (state == FR_MUL2) p2 <= prod[63:0];
    if (state == FR_SUM) begin
      // compare flags from the operands as given: an*bd against bn*ad
      logic signed [63:0] lhs, rhs;
      lhs = 64'(op.a_num) * $signed({33'b0, op.b_den});
      rhs = 64'(op.b_num) * $signed({33'b0, op.a_den});
      job.neg     <= n_fix[65];
      job.mag     <= n_fix[65] ? 64'(-n_fix) : n_fix[63:0];
      job.den     <= d_fix[63:0];
      job.a_less  <= lhs < rhs;
      job.a_equal <= lhs == rhs;
    end
  end

endmodule : rau_front
`default_nettype wire

// ===== rtl/rau_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rau_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module rau_queue
  import rau_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wdata,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      rdata
);

  job_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  a_no_overflow:  assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue underflow");
  a_cnt_range:    assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count out of range");

endmodule : rau_queue
`default_nettype wire

// ===== rtl/rau_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rau_back
// Binary gcd, two restoring divisions, range check; strobes the result.
// ----------------------------------------------------------------------------
module rau_back
  import rau_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  wire job_t q_data,
  output logic      pop,
  output logic      done,
  output out_item_t result
);

  bk_state_t  state, state_next;
  job_t       jb;
  logic [63:0] x, y, g;
  logic [6:0]  sh;
  logic [63:0] quo, rem;
  logic [63:0] qn;
  logic [6:0]  bitc;
  logic [64:0] rem_sh;
  logic [64:0] rem_try;
  localparam logic [63:0] Lim = 64'(1) << (WIDTH - 1);

  assign rem_sh  = {rem, quo[63]};
  assign rem_try = rem_sh - {1'b0, g};

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (!q_empty) state_next = BK_TWOS;
      BK_TWOS: begin
        if (x == '0 || y == '0) state_next = BK_DONE;
        else if (!x[0] && !y[0]) state_next = BK_TWOS;
        else state_next = BK_ODDX;
      end
      BK_ODDX: if (x[0]) state_next = BK_LOOP;
      BK_LOOP: if (y == '0) state_next = BK_DIVN;
      BK_DIVN: if (bitc == 7'd63) state_next = BK_DIVD;
      BK_DIVD: if (bitc == 7'd63) state_next = BK_DONE;
      BK_DONE: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  assign pop = (state == BK_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= (state == BK_DONE);
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        jb <= q_data;
        x  <= q_data.mag;
        y  <= q_data.den;
        sh <= '0;
      end
      BK_TWOS: begin
        if (x == '0 || y == '0) begin
          // zero numerator reduces to 0/1, zero denominator to +-1/0
          g   <= x | y;
          qn  <= 64'(x != '0);
          quo <= 64'(y != '0);
        end else if (!x[0] && !y[0]) begin
          x  <= x >> 1;
          y  <= y >> 1;
          sh <= sh + 7'd1;
        end
      end
      BK_ODDX: if (!x[0]) x <= x >> 1;
      BK_LOOP: begin
        if (y == '0) begin
          g    <= x << sh;
          quo  <= jb.mag;
          rem  <= '0;
          bitc <= '0;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x > y) begin
          x <= y;
          y <= x - y;
        end else begin
          y <= y - x;
        end
      end
      BK_DIVN, BK_DIVD: begin
        if (state == BK_DIVN && bitc == 7'd63) begin
          qn   <= {quo[62:0], !rem_try[64]};
          quo  <= jb.den;
          rem  <= '0;
          bitc <= '0;
        end else begin
          if (!rem_try[64]) begin
            rem <= rem_try[63:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            quo <= {quo[62:0], 1'b0};
          end
          bitc <= bitc + 7'd1;
        end
      end
      BK_DONE: begin
        result.a_less  <= jb.a_less;
        result.a_equal <= jb.a_equal;
        result.res_num <= '0;
        result.res_den <= '0;
        if (g == '0) begin
          result.status <= ST_UNDEF;
        end else if ((jb.neg ? qn > Lim : qn > Lim - 64'd1) || quo > Lim - 64'd1) begin
          result.status <= ST_OVF;
        end else begin
          result.status  <= ST_OK;
          result.res_num <= 32'(jb.neg ? -qn : qn);
          result.res_den <= 31'(quo);
        end
      end
      default: ;
    endcase
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst) pop |=> state == BK_TWOS)
    else $error("pop without gcd start");
  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_gcd_odd:  assert property (@(posedge clk) disable iff (rst)
                (state == BK_LOOP) |-> x[0])
    else $error("gcd loop lost odd x");

endmodule : rau_back
`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction add/sub/mul/div/normalize with gcd reduction and compare flags.
// ----------------------------------------------------------------------------
// Raise start with the operands while busy is low; that edge takes the
// transaction. The front then holds busy high through two cross products on a
// shared multiplier, sum and sign fix, and hand-off, and passes the job to a
// two-entry queue; while the queue is full busy stays high until a slot frees,
// so a second transaction can wait while the back works. The back loads the
// job, runs a binary gcd, one shift or subtract per cycle, then two 64-bit
// restoring divisions, and finishes with a range check. A zero numerator or
// denominator skips the gcd loop and the divisions. Results come out in order,
// each for one cycle with done high; the receiver cannot stall it, so capture
// it then.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire in_item_t in_item,
  output logic          busy,
  output logic          done,
  output out_item_t     result
);

  logic push, q_full, q_empty, pop;
  job_t fr_job, q_data;

  rau_front u_front (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .push(push), .job(fr_job), .q_full(q_full)
  );

  rau_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(fr_job), .full(q_full),
    .pop(pop), .empty(q_empty), .rdata(q_data)
  );

  rau_back #(.WIDTH(WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_data(q_data),
    .pop(pop), .done(done), .result(result)
  );

endmodule : rational_arithmetic_unit
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Checks the rational arithmetic unit: a directed table of fractions followed
// by random transactions; random results and directed rows without a written
// result are compared against an in-bench predictor of the reduced fraction, the compare flags and the status.
// ----------------------------------------------------------------------------
module testbench;
  import rau_pkg::*;

  localparam int unsigned Width    = 32;
  localparam int unsigned NumRand  = 750;
  localparam int unsigned Watchdog = 20000;
  localparam int unsigned Drain    = 400;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      done;
  out_item_t result;

  rational_arithmetic_unit #(.WIDTH(Width)) dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .done(done), .result(result)
  );

  always #4 clk = ~clk;

  // Expected results, oldest first.
  out_item_t pending_fracs[$];
  int        errors = 0;
  int        idle_cycles = 0;

  // Binary gcd on 64-bit magnitudes.
  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    int          sh;
    logic [63:0] t;
    sh = 0;
    if (x == 0) return y;
    if (y == 0) return x;
    while (((x | y) & 64'd1) == 0) begin
      x = x >> 1;
      y = y >> 1;
      sh++;
    end
    while (x[0] == 1'b0) x = x >> 1;
    while (y != 0) begin
      while (y[0] == 1'b0) y = y >> 1;
      if (x > y) begin
        t = x;
        x = y;
        y = t;
      end
      y = y - x;
    end
    return x << sh;
  endfunction

  // Reduced fraction for one transaction.
  function automatic out_item_t reduce_frac(in_item_t it);
    out_item_t        r;
    logic signed [63:0] an, ad, bn, bd, n, d, lhs, rhs;
    logic [63:0]      mag, den, g, lim;
    logic             neg;
    an = 64'(it.a_num);
    ad = {33'd0, it.a_den};
    bn = 64'(it.b_num);
    bd = {33'd0, it.b_den};
    case (it.kind)
      KIND_ADD: begin
        n = an * bd + bn * ad;
        d = ad * bd;
      end
      KIND_SUB: begin
        n = an * bd - bn * ad;
        d = ad * bd;
      end
      KIND_MUL: begin
        n = an * bn;
        d = ad * bd;
      end
      KIND_DIV: begin
        n = an * bd;
        d = ad * bn;
      end
      default: begin
        n = an;
        d = ad;
      end
    endcase
    lhs = an * bd;
    rhs = bn * ad;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    neg = n < 0;
    mag = neg ? -n : n;
    den = d;
    r = '0;
    r.a_less  = lhs < rhs;
    r.a_equal = lhs == rhs;
    g = gcd64(mag, den);
    if (g == 0) begin
      r.status = ST_UNDEF;
    end else begin
      mag = mag / g;
      den = den / g;
      lim = 64'd1 << (Width - 1);
      if ((neg ? mag > lim : mag > lim - 1) || den > lim - 1) begin
        r.status = ST_OVF;
      end else begin
        r.status  = ST_OK;
        r.res_num = neg ? 32'(-mag) : 32'(mag);
        r.res_den = 31'(den);
      end
    end
    return r;
  endfunction

  // Directed rows; has_exp marks rows whose result is written out here.
  typedef struct {
    in_item_t  op;
    logic      has_exp;
    out_item_t exp_frac;
  } dir_row_t;

  localparam logic signed [31:0] NMin = 32'sh8000_0000;
  localparam logic signed [31:0] NMax = 32'sh7fff_ffff;
  localparam logic [30:0]        DMax = 31'h7fff_ffff;

  dir_row_t dir_rows[] = '{
    // 1/2 + 1/3 = 5/6
    '{'{KIND_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3}, 1'b1, '{32'sd5, 31'd6, 1'b0, 1'b0, ST_OK}},
    // 1/2 - 1/2 = 0/1
    '{'{KIND_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2}, 1'b1, '{32'sd0, 31'd1, 1'b0, 1'b1, ST_OK}},
    // 0/0 normalized: undefined
    '{'{KIND_NORM, 32'sd0, 31'd0, 32'sd3, 31'd4}, 1'b1, '{32'sd0, 31'd0, 1'b0, 1'b1, ST_UNDEF}},
    // -5/0 normalizes to -1/0
    '{'{KIND_NORM, -32'sd5, 31'd0, 32'sd1, 31'd1}, 1'b1, '{-32'sd1, 31'd0, 1'b1, 1'b0, ST_OK}},
    // -6/4 -> -3/2
    '{'{KIND_NORM, -32'sd6, 31'd4, 32'sd0, 31'd1}, 1'b1, '{-32'sd3, 31'd2, 1'b1, 1'b0, ST_OK}},
    // max*max overflows
    '{'{KIND_MUL, NMax, 31'd1, NMax, 31'd1}, 1'b1, '{32'sd0, 31'd0, 1'b0, 1'b1, ST_OVF}},
    // min/1 fits exactly
    '{'{KIND_NORM, NMin, 31'd1, NMin, 31'd1}, 1'b1, '{NMin, 31'd1, 1'b0, 1'b1, ST_OK}},
    // divide by negative flips sign
    '{'{KIND_DIV, 32'sd3, 31'd4, -32'sd3, 31'd8}, 1'b1, '{-32'sd2, 31'd1, 1'b0, 1'b0, ST_OK}},
    // unused kind codes act as normalize
    '{'{3'd5, 32'sd4, 31'd8, 32'sd1, 31'd1}, 1'b1, '{32'sd1, 31'd2, 1'b1, 1'b0, ST_OK}},
    '{'{3'd6, NMax, DMax, NMin, DMax}, 1'b0, '0},
    '{'{3'd7, NMin, DMax, NMax, 31'd1}, 1'b0, '0},
    '{'{KIND_ADD, NMax, DMax, NMax, DMax}, 1'b0, '0},
    '{'{KIND_SUB, NMin, 31'd1, NMax, 31'd1}, 1'b0, '0},
    '{'{KIND_MUL, NMin, DMax, NMin, DMax}, 1'b0, '0},
    '{'{KIND_DIV, NMax, 31'd1, 32'sd0, 31'd1}, 1'b0, '0},
    '{'{KIND_DIV, 32'sd0, 31'd0, 32'sd0, 31'd0}, 1'b0, '0},
    '{'{KIND_ADD, 32'sd1, 31'd0, -32'sd1, 31'd0}, 1'b0, '0},
    '{'{KIND_MUL, NMin, 31'd1, -32'sd1, 31'd1}, 1'b0, '0},
    '{'{KIND_NORM, NMax, DMax, 32'sd0, 31'd0}, 1'b0, '0}
  };

  // Random fraction: mostly small parts so reductions stay in range,
  // occasionally the full field width.
  function automatic in_item_t rand_frac();
    in_item_t it;
    it.kind = 3'($urandom_range(7));
    case ($urandom_range(3))
      0: begin
        it.a_num = $urandom;
        it.a_den = 31'($urandom);
        it.b_num = $urandom;
        it.b_den = 31'($urandom);
      end
      1: begin
        it.a_num = $signed(32'($urandom_range(60000))) - 30000;
        it.a_den = 31'($urandom_range(30000));
        it.b_num = $signed(32'($urandom_range(60000))) - 30000;
        it.b_den = 31'($urandom_range(30000));
      end
      default: begin
        it.a_num = $signed(32'($urandom_range(40))) - 20;
        it.a_den = 31'($urandom_range(12));
        it.b_num = $signed(32'($urandom_range(40))) - 20;
        it.b_den = 31'($urandom_range(12));
      end
    endcase
    return it;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(3);
  endfunction

  // Present one transaction and hold it until the unit takes it. With no
  // gap, start stays high into the next transaction.
  task automatic send_frac(in_item_t it, logic has_exp, out_item_t exp_frac);
    int g;
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge: busy was low with start high
    pending_fracs.insert(pending_fracs.size(), has_exp ? exp_frac : reduce_frac(it));
  endtask

  // Result checker: each done strobe is matched to the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (pending_fracs.size() == 0) begin
        $error("unexpected result %h", result);
        errors++;
      end else begin
        want = pending_fracs.pop_front();
        if (result.res_num !== want.res_num) begin
          $error("res_num exp %0d got %0d", want.res_num, result.res_num);
          errors++;
        end
        if (result.res_den !== want.res_den) begin
          $error("res_den exp %0d got %0d", want.res_den, result.res_den);
          errors++;
        end
        if (result.a_less !== want.a_less) begin
          $error("a_less exp %0b got %0b", want.a_less, result.a_less);
          errors++;
        end
        if (result.a_equal !== want.a_equal) begin
          $error("a_equal exp %0b got %0b", want.a_equal, result.a_equal);
          errors++;
        end
        if (result.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, result.status);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no transaction in either direction.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= Watchdog) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) send_frac(dir_rows[i].op, dir_rows[i].has_exp, dir_rows[i].exp_frac);
    for (k = 0; k < NumRand; k++) send_frac(rand_frac(), 1'b0, '0);
    start <= 1'b0;
    while (pending_fracs.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
    if (errors == 0 && pending_fracs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule : testbench
`default_nettype wire

// ===== filelist.f =====
rtl/rau_pkg.sv
rtl/rau_front.sv
rtl/rau_queue.sv
rtl/rau_back.sv
rtl/rational_arithmetic_unit.sv
tb/testbench.sv
